// ===== hdl/nes_mapper67_bank_irq_core_defines.svh =====
// Assertion macros shared by the bank and scanline-interrupt mapper RTL.
// Included by the modules that carry concurrent assertions; needs clk and rst_n in scope.
`ifndef NES_MAPPER67_BANK_IRQ_CORE_DEFINES_SVH
`define NES_MAPPER67_BANK_IRQ_CORE_DEFINES_SVH

// Condition must hold in the same cycle as the trigger.
`define NM67_ASSERT_SAME(label, trig, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
    else $error("nm67 assertion failed");

// Condition must hold in the cycle after the trigger.
`define NM67_ASSERT_NEXT(label, trig, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
    else $error("nm67 assertion failed");

`endif

// ===== hdl/nm67_pkg.sv =====
// Shared types and constants for the bank and scanline-interrupt mapper.
// Used by nm67_mod_unit and nes_mapper67_bank_irq_core; no dependencies.
package nm67_pkg;

  // Command codes carried in the input tuser field.
  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_TICK  = 2'd1;
  localparam logic [1:0] CMD_INIT  = 2'd2;

  // Register select codes: CPU address bits 15..11.
  localparam logic [4:0] REG_CHR0   = 5'h11;  // 0x8800
  localparam logic [4:0] REG_CHR1   = 5'h13;  // 0x9800
  localparam logic [4:0] REG_CHR2   = 5'h15;  // 0xA800
  localparam logic [4:0] REG_CHR3   = 5'h17;  // 0xB800
  localparam logic [4:0] REG_IRQ_LD = 5'h19;  // 0xC800
  localparam logic [4:0] REG_IRQ_EN = 5'h1B;  // 0xD800
  localparam logic [4:0] REG_MIRROR = 5'h1D;  // 0xE800
  localparam logic [4:0] REG_PRG    = 5'h1F;  // 0xF800

  // Configuration register indexes.
  localparam logic CFG_CHR_SIZE = 1'b0;
  localparam logic CFG_PRG_SIZE = 1'b1;

  localparam logic [8:0] LAST_VISIBLE_LINE = 9'd239;
  localparam logic [7:0] IRQ_MATCH         = 8'hF6;
  localparam int         IRQ_EN_BIT        = 4;     // data bit that sets the enable

  localparam int MOD_W = 11;  // widest modulus: 8 * 255

  typedef struct packed {
    logic             start;
    logic [7:0]       dividend;
    logic [MOD_W-1:0] modulus;
  } mu_ctrl_t;

  typedef struct packed {
    logic       done;
    logic [7:0] rem;
  } mu_sts_t;

endpackage

// ===== hdl/nes_mapper67_bank_irq_core.sv =====
// Top level of the cartridge bank mapper with scanline interrupt.
// Depends on nm67_pkg, nm67_mod_unit and nes_mapper67_bank_irq_core_defines.svh.
//
// Usage: each input transaction carries one command in in_tuser (CPU write,
// horizontal-sync tick or init) with its address, data, scanline and render
// flag in in_tdata. Every input transaction yields exactly one output
// transaction that reports the four CHR pair pages, the PRG page, the
// mirroring mode and whether this tick raised the interrupt request.
// The configuration port sets the CHR and PRG ROM sizes; write it only while
// the block is idle.
// Timing: the block takes one transaction at a time. Init, tick, mirroring and
// IRQ register writes are applied in the execute state, and the result is then
// loaded into the output register from the done state. CHR and PRG bank writes
// reduce the doubled data byte modulo the ROM size in a shared bit-serial
// remainder unit, one bit per cycle, and their result is loaded into the
// output register once the remainder unit has finished with the last bit.
// A finished result waits in the output register; while the receiver stalls
// the next transaction can be accepted and processed, and it completes once
// the output register has been taken. Reset clears all mapper state and sets
// both ROM sizes to one unit; no output is pending after reset.
module nes_mapper67_bank_irq_core (
  input  logic        clk,
  input  logic        rst_n,
  // Input channel.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // address[15:0], data[23:16], scanline[32:24],
                                  // render_enabled[33], zero fill[39:34]
  input  logic [1:0]  in_tuser,   // command[1:0]
  // Result channel.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // chr_pair0_page[7:0], chr_pair1_page[15:8],
                                  // chr_pair2_page[23:16], chr_pair3_page[31:24],
                                  // prg_low_page[39:32], mirroring[41:40],
                                  // irq_request[42], zero fill[47:43]
  // Configuration port.
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_wdata
);
  import nm67_pkg::*;

`include "nes_mapper67_bank_irq_core_defines.svh"

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_CALC = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0] state_r;

  // Configuration.
  logic [7:0] chr_size_r;
  logic [7:0] prg_size_r;

  // Latched transaction.
  logic [1:0] cmd_r;
  logic [4:0] sel_r;
  logic [7:0] data_r;
  logic [8:0] line_r;
  logic       render_r;

  // Mapper state.
  logic [7:0] chr_base_r [4];
  logic [7:0] prg_base_r;
  logic [1:0] mirror_r;
  logic       irq_on_r;
  logic [7:0] irq_count_r;
  logic [7:0] irq_reload_r;
  logic       irq_r;

  // Output register.
  logic        out_tvalid_r;
  logic [47:0] out_tdata_r;

  mu_ctrl_t mu_ctrl;
  mu_sts_t  mu_sts;

  logic       in_acc;
  logic       out_free;
  logic       is_chr_sel;
  logic       tick_live;
  logic       irq_hit;
  logic [7:0] count_dec;
  logic [7:0] chr_top;

  assign in_acc    = in_tvalid && in_tready;
  assign in_tready = (state_r == ST_IDLE);
  assign out_free  = !out_tvalid_r || out_tready;

  assign is_chr_sel = (sel_r == REG_CHR0) || (sel_r == REG_CHR1) ||
                      (sel_r == REG_CHR2) || (sel_r == REG_CHR3);

  // A tick only counts on a visible, rendering scanline with the IRQ enabled.
  assign tick_live = irq_on_r && (line_r <= LAST_VISIBLE_LINE) && render_r;
  assign count_dec = irq_count_r - 8'd1;
  assign irq_hit   = tick_live && (count_dec == IRQ_MATCH);

  // Eight times the CHR size, wrapped to the page width, for the init defaults.
  assign chr_top = {chr_size_r[4:0], 3'b000};

  // The remainder unit sees the doubled data byte and the ROM size as a page count.
  always_comb begin
    mu_ctrl.start    = 1'b0;
    mu_ctrl.dividend = {data_r[6:0], 1'b0};
    mu_ctrl.modulus  = is_chr_sel ? {chr_size_r, 3'b000} : {2'b00, prg_size_r, 1'b0};
    if ((state_r == ST_EXEC) && (cmd_r == CMD_WRITE) && (is_chr_sel || sel_r == REG_PRG)) begin
      mu_ctrl.start = 1'b1;
    end
  end

  nm67_mod_unit u_mod (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl_i (mu_ctrl),
    .sts_o  (mu_sts)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chr_size_r <= 8'd1;
      prg_size_r <= 8'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CHR_SIZE: chr_size_r <= cfg_wdata;
        CFG_PRG_SIZE: prg_size_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r    <= in_tuser;
      sel_r    <= in_tdata[15:11];
      data_r   <= in_tdata[23:16];
      line_r   <= in_tdata[32:24];
      render_r <= in_tdata[33];
    end
  end

  // Sequencer and mapper state updates.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      chr_base_r   <= '{default: 8'd0};
      prg_base_r   <= '0;
      mirror_r     <= '0;
      irq_on_r     <= 1'b0;
      irq_count_r  <= '0;
      irq_reload_r <= '0;
      irq_r        <= 1'b0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            state_r <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          // Bank writes go on to the remainder unit; everything else is done here.
          irq_r   <= (cmd_r == CMD_TICK) && irq_hit;
          state_r <= mu_ctrl.start ? ST_CALC : ST_DONE;
          case (cmd_r)
            CMD_WRITE: begin
              case (sel_r)
                REG_IRQ_LD: begin
                  irq_count_r  <= irq_reload_r;
                  irq_reload_r <= data_r;
                end
                REG_IRQ_EN: irq_on_r <= data_r[IRQ_EN_BIT];
                REG_MIRROR: mirror_r <= data_r[1:0];
                default: ;
              endcase
            end
            CMD_TICK: begin
              if (tick_live) begin
                irq_count_r <= irq_hit ? irq_reload_r : count_dec;
              end
            end
            CMD_INIT: begin
              chr_base_r[0] <= 8'd0;
              chr_base_r[1] <= 8'd2;
              chr_base_r[2] <= chr_top - 8'd4;
              chr_base_r[3] <= chr_top - 8'd2;
              prg_base_r    <= '0;
              irq_on_r      <= 1'b0;
              irq_count_r   <= '0;
              irq_reload_r  <= '0;
            end
            default: ;
          endcase
        end
        ST_CALC: begin
          if (mu_sts.done) begin
            state_r <= ST_DONE;
            case (sel_r)
              REG_CHR0: chr_base_r[0] <= mu_sts.rem;
              REG_CHR1: chr_base_r[1] <= mu_sts.rem;
              REG_CHR2: chr_base_r[2] <= mu_sts.rem;
              REG_CHR3: chr_base_r[3] <= mu_sts.rem;
              default:  prg_base_r    <= mu_sts.rem;
            endcase
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // Output register: loaded with a snapshot of the updated state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if ((state_r == ST_DONE) && out_free) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == ST_DONE) && out_free) begin
      out_tdata_r <= {5'b00000, irq_r, mirror_r, prg_base_r,
                      chr_base_r[3], chr_base_r[2], chr_base_r[1], chr_base_r[0]};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // The block is busy in the cycle after it takes a transaction.
  `NM67_ASSERT_NEXT(a_busy_after_accept, in_acc, !in_tready)
  // The remainder unit only finishes while the sequencer waits for it.
  `NM67_ASSERT_SAME(a_done_in_calc, mu_sts.done, state_r == ST_CALC)
  // An interrupt request can only come from a sync tick.
  `NM67_ASSERT_SAME(a_irq_from_tick, (state_r == ST_DONE) && irq_r, cmd_r == CMD_TICK)
  // A stalled result is never overwritten by the next transaction.
  `NM67_ASSERT_NEXT(a_hold_stalled, out_tvalid_r && !out_tready, out_tvalid_r)

endmodule

// ===== hdl/nm67_mod_unit.sv =====
// Bit-serial restoring remainder unit: 8-bit dividend modulo an 11-bit modulus.
// Depends on nm67_pkg for the control and status structs.
module nm67_mod_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  nm67_pkg::mu_ctrl_t ctrl_i,
  output nm67_pkg::mu_sts_t  sts_o
);
  import nm67_pkg::*;

  logic             busy_r;
  logic [2:0]       cnt_r;
  logic [7:0]       rem_r;
  logic [7:0]       dvd_r;
  logic [MOD_W-1:0] mod_r;
  logic             done_r;

  logic [8:0]       trial;
  logic [MOD_W-1:0] diff;
  logic             ge;
  logic [7:0]       rem_nxt;

  // One quotient bit per cycle. The running remainder never exceeds the
  // dividend prefix, so it stays within 8 bits; a zero modulus leaves it untouched.
  always_comb begin
    trial   = {rem_r, dvd_r[7]};
    ge      = {2'b00, trial} >= mod_r;
    diff    = {2'b00, trial} - mod_r;
    rem_nxt = ge ? diff[7:0] : trial[7:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (ctrl_i.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 3'd1;
        if (cnt_r == 3'd7) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl_i.start) begin
      rem_r <= '0;
      dvd_r <= ctrl_i.dividend;
      mod_r <= ctrl_i.modulus;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      dvd_r <= {dvd_r[6:0], 1'b0};
    end
  end

  assign sts_o.done = done_r;
  assign sts_o.rem  = rem_r;

endmodule
